### rtl/core/cdst_pkg.sv
`default_nettype none
// ============================================================================
// Countdown and stopwatch timer package
// Shared types, operation and command codes, register indexes and constants.
// ============================================================================
package cdst_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_KEY_START = 3'd1;
    localparam logic [2:0] OP_KEY_ZERO  = 3'd2;
    localparam logic [2:0] OP_RESTART   = 3'd3;
    localparam logic [2:0] OP_SUSPEND   = 3'd4;
    localparam logic [2:0] OP_RESUME    = 3'd5;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_TOGGLE  = 3'd1;
    localparam logic [2:0] CMD_ZERO    = 3'd2;
    localparam logic [2:0] CMD_RESTART = 3'd3;
    localparam logic [2:0] CMD_SUSPEND = 3'd4;
    localparam logic [2:0] CMD_RESUME  = 3'd5;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_ALARM = 1'b1;

    localparam logic MODE_COUNTDOWN = 1'b0;
    localparam logic MODE_STOPWATCH = 1'b1;

    localparam logic [12:0] ALARM_RESET = 13'd60;
    localparam logic [6:0]  MAX_MINUTES = 7'd99;

    // Division by 1000 is a multiply by ceil(2^38 / 1000) and a shift by 38.
    localparam logic [28:0] RECIP_1000  = 29'd274877907;
    localparam int unsigned SHIFT_1000  = 38;
    // Division by 60 is a shift by 2, then a multiply by ceil(2^25 / 15).
    localparam logic [21:0] RECIP_15    = 22'd2236963;
    localparam int unsigned SHIFT_15    = 25;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic       display_update;
        logic       alarm_fired;
    } t_out;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now_ms;
    } t_cmd;

endpackage
`default_nettype wire

### rtl/core/countdown_and_stopwatch_timer.sv
`default_nettype none
// ============================================================================
// Countdown and stopwatch timer
// Top level: configuration registers, front end, command queue and back end.
// ============================================================================
// The timer takes one request per clock cycle and sustains that rate as long
// as results are taken. An accepted request passes through the command queue,
// then the back-end stages r1, r2, r3, r4 and the output register; the two
// reciprocal multiplies (milliseconds to seconds, seconds to minutes) sit in
// the back end. A stalled output freezes the back end; the queue then fills
// and stalls the input. Configuration writes are always ready.
module countdown_and_stopwatch_timer #(
    parameter int unsigned QUEUE_DEPTH = cdst_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire cdst_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output cdst_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic           i_cfg_index,
    input  wire logic [12:0]    i_cfg_data
);

    logic           r_mode;
    logic [12:0]    r_alarm_seconds;
    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    cdst_pkg::t_cmd front_cmd;
    cdst_pkg::t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= cdst_pkg::MODE_COUNTDOWN;
            r_alarm_seconds <= cdst_pkg::ALARM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cdst_pkg::CFG_MODE:  r_mode          <= i_cfg_data[0];
                cdst_pkg::CFG_ALARM: r_alarm_seconds <= i_cfg_data;
                default:             r_mode          <= r_mode;
            endcase
        end
    end

    cdst_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_mode     (r_mode),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    cdst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    cdst_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (r_mode),
        .i_alarm_seconds (r_alarm_seconds),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_data      (o_out_data)
    );

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.minutes <= cdst_pkg::MAX_MINUTES &&
                         o_out_data.seconds <= 6'd59))
        else $error("Result minutes or seconds out of range.");

    a_alarm_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.alarm_fired) |->
            (o_out_data.minutes == 7'd0 && o_out_data.seconds == 6'd0))
        else $error("Alarm fired with a nonzero shown time.");

    a_no_pop_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !q_pop)
        else $error("Command taken from the queue while the output is stalled.");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> (!q_push && q_valid))
        else $error("Queue written while full.");

endmodule
`default_nettype wire

### rtl/core/cdst_front.sv
`default_nettype none
// ============================================================================
// Timer front end
// Accepts requests and turns them into commands, dropping those that do nothing.
// ============================================================================
module cdst_front (
    input  wire logic          i_in_valid,
    input  wire cdst_pkg::t_in i_in_data,
    input  wire logic          i_mode,
    input  wire logic          i_q_full,
    output logic               o_in_stall,
    output logic               o_push,
    output cdst_pkg::t_cmd     o_cmd
);

    logic keep;

    always_comb begin
        keep         = 1'b0;
        o_cmd.kind   = cdst_pkg::CMD_TICK;
        o_cmd.now_ms = i_in_data.now_ms;
        unique case (i_in_data.operation)
            cdst_pkg::OP_TICK: begin
                keep       = 1'b1;
                o_cmd.kind = cdst_pkg::CMD_TICK;
            end
            cdst_pkg::OP_KEY_START: begin
                keep       = (i_mode == cdst_pkg::MODE_STOPWATCH);
                o_cmd.kind = cdst_pkg::CMD_TOGGLE;
            end
            cdst_pkg::OP_KEY_ZERO: begin
                keep       = (i_mode == cdst_pkg::MODE_STOPWATCH);
                o_cmd.kind = cdst_pkg::CMD_ZERO;
            end
            cdst_pkg::OP_RESTART: begin
                keep       = 1'b1;
                o_cmd.kind = cdst_pkg::CMD_RESTART;
            end
            cdst_pkg::OP_SUSPEND: begin
                keep       = 1'b1;
                o_cmd.kind = cdst_pkg::CMD_SUSPEND;
            end
            cdst_pkg::OP_RESUME: begin
                keep       = 1'b1;
                o_cmd.kind = cdst_pkg::CMD_RESUME;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full && keep;

endmodule
`default_nettype wire

### rtl/core/cdst_queue.sv
`default_nettype none
// ============================================================================
// Timer command queue
// Small first-in first-out buffer between the front end and the back end.
// ============================================================================
module cdst_queue #(
    parameter int unsigned DEPTH = cdst_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cdst_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output cdst_pkg::t_cmd      o_cmd
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cdst_pkg::t_cmd r_mem [DEPTH];
    logic [IW-1:0]  r_wr_ptr;
    logic [IW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [IW-1:0]  n_wr_ptr;
    logic [IW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == IW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == IW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

### rtl/core/cdst_back.sv
`default_nettype none
// ============================================================================
// Timer back end
// Executes commands in order: timer state, divide by 1000, change detection
// and alarm, divide by 60, then minutes and seconds into the output register.
// ============================================================================
module cdst_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_mode,
    input  wire logic [12:0]    i_alarm_seconds,
    input  wire logic           i_cmd_valid,
    input  wire cdst_pkg::t_cmd i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output cdst_pkg::t_out      o_out_data
);

    typedef struct packed {
        logic tick;
        logic refresh;
        logic restart;
        logic gate;
    } t_ctl;

    logic en;

    // Timer state.
    logic [31:0] r_alarm_start, n_alarm_start;
    logic        r_running, n_running;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_run_start, n_run_start;
    logic        r_suspended, n_suspended;
    logic [31:0] diff_run;
    logic [31:0] run_sum;
    logic [31:0] div;
    logic        clear_div;
    t_ctl        ctl0;

    // Stage registers.
    logic        r1_valid;
    logic [31:0] r1_div;
    t_ctl        r1_ctl;
    logic [60:0] prod_1000;
    logic        r2_valid;
    logic [22:0] r2_gone;
    t_ctl        r2_ctl;

    // Change detection state.
    logic [22:0] r_last_shown, n_last_shown;
    logic        r_last_valid, n_last_valid;
    logic        r_alarm_done, n_alarm_done;
    logic [22:0] shown;
    logic        result2;
    logic        update2;
    logic        fired2;

    logic        r3_valid;
    logic [22:0] r3_v;
    logic        r3_update;
    logic        r3_fired;
    logic [42:0] prod_60;
    logic        r4_valid;
    logic [22:0] r4_v;
    logic [17:0] r4_q;
    logic        r4_update;
    logic        r4_fired;
    logic [6:0]  minutes4;
    logic [5:0]  seconds4;
    logic        r_out_valid;
    cdst_pkg::t_out r_out;

    assign en    = !r_out_valid || !i_out_stall;
    assign o_pop = en && i_cmd_valid;

    always_comb begin
        n_alarm_start = r_alarm_start;
        n_running     = r_running;
        n_acc         = r_acc;
        n_run_start   = r_run_start;
        n_suspended   = r_suspended;
        diff_run      = i_cmd.now_ms - r_run_start;
        run_sum       = r_acc + diff_run;
        clear_div     = 1'b0;
        ctl0          = '0;
        unique case (i_cmd.kind)
            cdst_pkg::CMD_TICK: begin
                ctl0.tick = 1'b1;
            end
            cdst_pkg::CMD_TOGGLE: begin
                ctl0.refresh = 1'b1;
                if (r_running) begin
                    n_acc     = run_sum;
                    n_running = 1'b0;
                end else begin
                    n_run_start = i_cmd.now_ms;
                    n_running   = 1'b1;
                end
            end
            cdst_pkg::CMD_ZERO: begin
                ctl0.refresh = 1'b1;
                clear_div    = 1'b1;
                n_running    = 1'b0;
                n_acc        = '0;
                n_run_start  = i_cmd.now_ms;
            end
            cdst_pkg::CMD_RESTART: begin
                ctl0.refresh  = 1'b1;
                ctl0.restart  = 1'b1;
                clear_div     = 1'b1;
                n_alarm_start = i_cmd.now_ms;
                n_running     = 1'b0;
                n_acc         = '0;
                n_run_start   = i_cmd.now_ms;
                n_suspended   = 1'b0;
            end
            cdst_pkg::CMD_SUSPEND: begin
                n_suspended = 1'b1;
            end
            cdst_pkg::CMD_RESUME: begin
                ctl0.refresh = 1'b1;
                n_suspended  = 1'b0;
            end
            default: begin
                ctl0 = '0;
            end
        endcase
        ctl0.gate = n_suspended;
        if (clear_div) begin
            div = '0;
        end else if (i_mode == cdst_pkg::MODE_STOPWATCH) begin
            div = r_running ? run_sum : r_acc;
        end else begin
            div = i_cmd.now_ms - r_alarm_start;
        end
    end

    assign prod_1000 = {29'b0, r1_div} * {32'b0, cdst_pkg::RECIP_1000};

    always_comb begin
        n_last_shown = r_last_shown;
        n_last_valid = r_last_valid;
        n_alarm_done = r_alarm_done;
        result2      = 1'b0;
        update2      = 1'b0;
        fired2       = 1'b0;
        if (i_mode == cdst_pkg::MODE_STOPWATCH) begin
            shown = r2_gone;
        end else if (r2_gone >= {10'b0, i_alarm_seconds}) begin
            shown = '0;
        end else begin
            shown = {10'b0, i_alarm_seconds} - r2_gone;
        end
        if (r2_ctl.tick) begin
            if (i_mode == cdst_pkg::MODE_COUNTDOWN && shown == '0 && !r_alarm_done) begin
                n_alarm_done = 1'b1;
                fired2       = 1'b1;
            end
            if (!r_last_valid || shown != r_last_shown) begin
                n_last_shown = shown;
                n_last_valid = 1'b1;
                update2      = !r2_ctl.gate;
                result2      = 1'b1;
            end
            if (fired2) begin
                result2 = 1'b1;
            end
        end else if (r2_ctl.refresh) begin
            n_last_valid = 1'b0;
            if (r2_ctl.restart) begin
                n_alarm_done = 1'b0;
            end
            result2 = !r2_ctl.gate;
            update2 = 1'b1;
        end
    end

    assign prod_60 = {22'b0, r3_v[22:2]} * {21'b0, cdst_pkg::RECIP_15};

    // The seconds are v - 60q; modulo 64 this equals v + 4q.
    assign minutes4 = (r4_q > 18'(cdst_pkg::MAX_MINUTES)) ? cdst_pkg::MAX_MINUTES : r4_q[6:0];
    assign seconds4 = r4_v[5:0] + {r4_q[3:0], 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_start <= '0;
            r_running     <= 1'b0;
            r_acc         <= '0;
            r_run_start   <= '0;
            r_suspended   <= 1'b0;
            r_last_shown  <= '0;
            r_last_valid  <= 1'b0;
            r_alarm_done  <= 1'b0;
            r1_valid      <= 1'b0;
            r2_valid      <= 1'b0;
            r3_valid      <= 1'b0;
            r4_valid      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (en) begin
            if (i_cmd_valid) begin
                r_alarm_start <= n_alarm_start;
                r_running     <= n_running;
                r_acc         <= n_acc;
                r_run_start   <= n_run_start;
                r_suspended   <= n_suspended;
            end
            if (r2_valid) begin
                r_last_shown <= n_last_shown;
                r_last_valid <= n_last_valid;
                r_alarm_done <= n_alarm_done;
            end
            r1_valid    <= i_cmd_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid && result2;
            r4_valid    <= r3_valid;
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_div    <= div;
            r1_ctl    <= ctl0;
            r2_gone   <= prod_1000[60:cdst_pkg::SHIFT_1000];
            r2_ctl    <= r1_ctl;
            r3_v      <= shown;
            r3_update <= update2;
            r3_fired  <= fired2;
            r4_v      <= r3_v;
            r4_q      <= prod_60[42:cdst_pkg::SHIFT_15];
            r4_update <= r3_update;
            r4_fired  <= r3_fired;
            r_out.minutes        <= minutes4;
            r_out.seconds        <= seconds4;
            r_out.display_update <= r4_update;
            r_out.alarm_fired    <= r4_fired;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
